// File: rtl/lzms_pkg.sv
package lzms_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int LA_DEPTH  = 16;

  localparam int WIN_AW = $clog2(WIN_DEPTH);
  localparam int WCNT_W = $clog2(WIN_DEPTH + 1);
  localparam int LA_AW  = $clog2(LA_DEPTH);
  localparam int LCNT_W = $clog2(LA_DEPTH + 1);

  // result word: found, offset, length, overflow, zero fill to whole bytes
  localparam int RES_BITS  = 1 + WCNT_W + LCNT_W + 1;
  localparam int RES_BYTES = (RES_BITS + 7) / 8;
  localparam int RES_W     = RES_BYTES * 8;

  typedef logic [7:0]        byte_t;
  typedef logic [WIN_AW-1:0] win_addr_t;
  typedef logic [WCNT_W-1:0] win_cnt_t;
  typedef logic [LCNT_W-1:0] la_cnt_t;
  typedef byte_t [LA_DEPTH-1:0] la_arr_t;

  // append target selector
  localparam logic FUNC_WINDOW    = 1'b0;
  localparam logic FUNC_LOOKAHEAD = 1'b1;

  // control from the sequencer to the match tracker
  typedef struct packed {
    logic      clear;
    logic      valid;
    win_addr_t pos;
  } scan_ctl_t;

endpackage

// File: rtl/lz77_longest_match_search.sv
// LZ77 longest-match search. Bytes stream in one per cycle on the slave side while the block is
// loading: tuser selects the target (0 window, 1 lookahead), tdata carries the byte. Up to 4096
// window bytes and 16 lookahead bytes are kept; extra bytes are dropped and reported as
// overflow. The request with tlast set is stored like any other and then starts the search,
// which reports the longest lookahead prefix found wholly inside the window, its backward
// offset from the window end (nearest wins on equal length) and a found flag that is low when
// either store was empty. The search walks the window memory one byte per cycle through its
// single read port. From the last request until the result is in the output register, also
// while the previous result still waits to leave it, the input is held off. The result waits
// in an output register, and loading of the next set goes on while it waits; both stores are
// empty again once the result is registered.
module lz77_longest_match_search
  import lzms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]       s_axis_tuser,  // [0] func
  input  logic             s_axis_tlast,  // last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [RES_W-1:0] m_axis_tdata   // [0] found, [13:1] match_offset,
                                          // [18:14] match_length, [19] overflow, rest zero
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e    state_q, state_d;

  // stores and fill counts
  win_cnt_t  win_cnt_q, win_cnt_d;
  la_cnt_t   la_cnt_q, la_cnt_d;
  logic      drop_q, drop_d;
  la_arr_t   la_q;

  // scan sequencer
  win_cnt_t  iss_q;
  logic      rd_vld_q;
  win_addr_t pos_q;

  // output register
  logic      out_vld_q;
  logic      out_found_q;
  win_cnt_t  out_off_q;
  la_cnt_t   out_len_q;
  logic      out_ovf_q;

  logic      accept, start, issue, out_free, done_fire;
  logic      win_full, la_full, win_we, la_we;
  byte_t     rd_data;
  scan_ctl_t scan_ctl;
  la_cnt_t   best_len;
  win_addr_t best_start;
  logic      res_found;
  win_cnt_t  res_off;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && s_axis_tlast;

  assign win_full = (win_cnt_q == WCNT_W'(WIN_DEPTH));
  assign la_full  = (la_cnt_q == LCNT_W'(LA_DEPTH));
  assign win_we   = accept && (s_axis_tuser[0] == FUNC_WINDOW) && !win_full;
  assign la_we    = accept && (s_axis_tuser[0] == FUNC_LOOKAHEAD) && !la_full;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign done_fire = (state_q == ST_DONE) && out_free;

  // one window read per cycle until every stored byte was issued
  assign issue = (state_q == ST_SCAN) && (iss_q != win_cnt_q);

  // fill counts, cleared as the result moves to the output register
  always_comb begin
    win_cnt_d = win_cnt_q;
    la_cnt_d  = la_cnt_q;
    drop_d    = drop_q;
    if (done_fire) begin
      win_cnt_d = '0;
      la_cnt_d  = '0;
      drop_d    = 1'b0;
    end else begin
      if (win_we) begin
        win_cnt_d = win_cnt_q + WCNT_W'(1);
      end
      if (la_we) begin
        la_cnt_d = la_cnt_q + LCNT_W'(1);
      end
      if (accept && !win_we && !la_we) begin
        drop_d = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start) begin
          if ((win_cnt_d != '0) && (la_cnt_d != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // last read data has been folded into the tracker
        if (!issue && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      win_cnt_q <= '0;
      la_cnt_q  <= '0;
      drop_q    <= 1'b0;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      win_cnt_q <= win_cnt_d;
      la_cnt_q  <= la_cnt_d;
      drop_q    <= drop_d;
      rd_vld_q  <= issue;
      if (start) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + WCNT_W'(1);
      end
      if (done_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // lookahead lanes, compared in parallel by the tracker, and the position of each window read
  always_ff @(posedge clk_i) begin
    if (la_we) begin
      la_q[la_cnt_q[LA_AW-1:0]] <= s_axis_tdata;
    end
    if (issue) begin
      pos_q <= iss_q[WIN_AW-1:0];
    end
  end

  lzms_win_ram u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_cnt_q[WIN_AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (issue),
    .raddr_i (iss_q[WIN_AW-1:0]),
    .rdata_o (rd_data)
  );

  assign scan_ctl.clear = start;
  assign scan_ctl.valid = rd_vld_q;
  assign scan_ctl.pos   = pos_q;

  lzms_matcher u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .rd_data_i    (rd_data),
    .la_i         (la_q),
    .la_cnt_i     (la_cnt_q),
    .best_len_o   (best_len),
    .best_start_o (best_start)
  );

  // tracker was cleared at the last request, so length is zero without a scan
  assign res_found = (win_cnt_q != '0) && (la_cnt_q != '0);
  assign res_off   = (best_len != '0) ? (win_cnt_q - WCNT_W'(best_start)) : '0;

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_found_q <= res_found;
      out_off_q   <= res_off;
      out_len_q   <= best_len;
      out_ovf_q   <= drop_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = RES_W'({out_ovf_q, out_len_q, out_off_q, out_found_q});

endmodule

// File: rtl/lzms_win_ram.sv
module lzms_win_ram
  import lzms_pkg::*;
(
  input  logic      clk_i,
  input  logic      we_i,
  input  win_addr_t waddr_i,
  input  byte_t     wdata_i,
  input  logic      re_i,
  input  win_addr_t raddr_i,
  output byte_t     rdata_o
);

  byte_t mem [WIN_DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lzms_matcher.sv
module lzms_matcher
  import lzms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  input  byte_t     rd_data_i,
  input  la_arr_t   la_i,
  input  la_cnt_t   la_cnt_i,
  output la_cnt_t   best_len_o,
  output win_addr_t best_start_o
);

  // alive[j]: window bytes ending at the current position equal lookahead[0..j]
  logic [LA_DEPTH-1:0] alive_q, alive_d;
  logic [LA_DEPTH-1:0] hit, chain;
  la_cnt_t             best_len_q, best_len_d;
  win_addr_t           best_start_q, best_start_d;
  logic                top_hit;
  logic [LA_AW-1:0]    top_j;
  la_cnt_t             top_len;
  win_addr_t           top_start;

  assign chain = {alive_q[LA_DEPTH-2:0], 1'b1};

  always_comb begin
    for (int j = 0; j < LA_DEPTH; j++) begin
      hit[j] = chain[j] && (rd_data_i == la_i[j]) && (LCNT_W'(j) < la_cnt_i);
    end
  end

  // longest run ending here
  always_comb begin
    top_hit = 1'b0;
    top_j   = '0;
    for (int j = 0; j < LA_DEPTH; j++) begin
      if (hit[j]) begin
        top_hit = 1'b1;
        top_j   = LA_AW'(j);
      end
    end
  end

  assign top_len   = LCNT_W'(top_j) + LCNT_W'(1);
  assign top_start = ctl_i.pos - WIN_AW'(top_j);

  always_comb begin
    alive_d      = alive_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    if (ctl_i.clear) begin
      alive_d    = '0;
      best_len_d = '0;
    end else if (ctl_i.valid) begin
      alive_d = hit;
      // later start wins a tie: smaller backward offset
      if (top_hit && (top_len >= best_len_q)) begin
        best_len_d   = top_len;
        best_start_d = top_start;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q    <= '0;
      best_len_q <= '0;
    end else begin
      alive_q    <= alive_d;
      best_len_q <= best_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_start_q <= best_start_d;
  end

  assign best_len_o   = best_len_q;
  assign best_start_o = best_start_q;

endmodule
